FILE: rtl/core/assert_macros.svh
// Assertion helper macros for the interpolation block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(label, cond, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/core/qnl_pkg.sv
// ----------------------------------------------------------------------------
// qnl_pkg
// Shared widths and the control struct of the nlerp pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package qnl_pkg;
  localparam int CompBitsDef = 16;
  localparam int NumLanes = 4;
  localparam int MagBits = 30;
  localparam int SumBits = 62;
  localparam int RootBits = 31;

  typedef struct packed {
    logic equal;
    logic zero;
  } qnl_ctl_t;
endpackage
`default_nettype wire

FILE: rtl/core/qnl_sqrt.sv
// ----------------------------------------------------------------------------
// qnl_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module qnl_sqrt
  import qnl_pkg::*;
#(
  parameter int DW = SumBits,
  parameter int RW = RootBits,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [DW-1:0] s_in,
  input  wire logic [SW-1:0] side_in,
  output logic      [RW-1:0] root,
  output logic      [SW-1:0] side_out
);
  logic [DW-1:0] rem_r  [RW+1];
  logic [RW-1:0] res_r  [RW+1];
  logic [SW-1:0] side_r [RW+1];

  always_comb begin
    rem_r[0]  = s_in;
    res_r[0]  = '0;
    side_r[0] = side_in;
  end

  for (genvar k = 0; k < RW; k++) begin : g_stg
    localparam int B = RW - 1 - k;
    logic [DW+1:0] trial;
    logic [RW-1:0] cand;
    // (res + 2^B)^2 - res^2 = (2*res + 2^B) * 2^B
    always_comb begin
      cand  = res_r[k] | (RW'(1) << B);
      trial = {2'b00, rem_r[k]}
            - (((DW+2)'(res_r[k]) << (B + 1)) | ((DW+2)'(1) << (2 * B)));
    end
    logic [DW-1:0] rem_nxt_r;
    logic [RW-1:0] res_nxt_r;
    logic [SW-1:0] sd_r;
    always_ff @(posedge clk) begin
      if (en) begin
        sd_r <= side_r[k];
        if (!trial[DW+1]) begin
          rem_nxt_r <= trial[DW-1:0];
          res_nxt_r <= cand;
        end else begin
          rem_nxt_r <= rem_r[k];
          res_nxt_r <= res_r[k];
        end
      end
    end
    always_comb begin
      rem_r[k+1]  = rem_nxt_r;
      res_r[k+1]  = res_nxt_r;
      side_r[k+1] = sd_r;
    end
  end

  assign root     = res_r[RW];
  assign side_out = side_r[RW];
endmodule
`default_nettype wire

FILE: rtl/core/qnl_div.sv
// ----------------------------------------------------------------------------
// qnl_div
// Pipelined restoring divider for one lane: quotient saturated and negated for a negative lane.
// ----------------------------------------------------------------------------
`default_nettype none
module qnl_div
  import qnl_pkg::*;
#(
  parameter int CW = CompBitsDef,
  parameter int NW = MagBits + CompBitsDef,
  parameter int DW = RootBits
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic          neg,
  output logic      [CW-1:0] q_out
);
  localparam int QW = CW + 1;
  localparam logic [QW-1:0] One = QW'(1) << (CW - 1);
  logic [NW-1:0] rem_r [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic [QW-1:0] quo_r [QW+1];
  logic          neg_r [QW+1];

  always_comb begin
    rem_r[0] = num; den_r[0] = den; quo_r[0] = '0; neg_r[0] = neg;
  end

  // quotient is below 2^(CW+1) since m*ONE + n/2 < 2*ONE*n
  for (genvar k = 0; k < QW; k++) begin : g_stg
    localparam int B = QW - 1 - k;
    logic [NW+QW:0] sub;
    always_comb sub = {(QW+1)'(0), rem_r[k]} - ((NW+QW+1)'(den_r[k]) << B);
    logic [NW-1:0] r_r; logic [DW-1:0] d_r; logic [QW-1:0] q_r; logic n_r;
    always_ff @(posedge clk) begin
      if (en) begin
        d_r <= den_r[k];
        n_r <= neg_r[k];
        if (!sub[NW+QW]) begin
          r_r <= sub[NW-1:0];
          q_r <= quo_r[k] | (QW'(1) << B);
        end else begin
          r_r <= rem_r[k];
          q_r <= quo_r[k];
        end
      end
    end
    always_comb begin
      rem_r[k+1] = r_r; den_r[k+1] = d_r; quo_r[k+1] = q_r; neg_r[k+1] = n_r;
    end
  end

  logic [QW-1:0] qs;
  always_comb begin
    qs = quo_r[QW];
    if (neg_r[QW]) begin
      if (qs > One) qs = One;
      q_out = CW'(-qs);
    end else begin
      if (qs > One - 1) qs = One - 1;
      q_out = qs[CW-1:0];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/quaternion_nlerp_unit.sv
// ----------------------------------------------------------------------------
// quaternion_nlerp_unit
// A fully pipelined nlerp: one item per cycle while the output is not stalled. The
// pipeline is made of six front stages, the bit-per-stage square root, the four
// per-lane bit-per-stage dividers and the output register. It advances only when
// the output register is free or being taken, so a stall holds every stage.
// ----------------------------------------------------------------------------
`default_nettype none
module quaternion_nlerp_unit
  import qnl_pkg::*;
#(
  parameter int COMPONENT_BITS = CompBitsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // from_x, from_y, from_z, from_w, to_x, to_y, to_z, to_w, weight
  input  wire logic [143:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_x, out_y, out_z, out_w, degenerate, zero fill
  output logic [71:0]      out_tdata
);
  localparam int CW = COMPONENT_BITS;
  localparam int PW = 2 * CW + 1;
  localparam int NW = MagBits + CW;
  localparam int LAT = 6 + RootBits + CW + 1 + 1;
  localparam logic [CW:0] One = (CW+1)'(1) << (CW - 1);

  logic [LAT-1:0] vld_r;
  logic adv;
  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv && rst_n;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[LAT-2:0], in_tvalid};
  end

  // stage 1: unpack, clamp weight, equality, products for the dot sign
  logic signed [CW-1:0] f [NumLanes];
  logic signed [CW-1:0] g [NumLanes];
  logic [CW:0] t;
  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      f[i] = in_tdata[16*i +: CW];
      g[i] = in_tdata[16*(i+4) +: CW];
    end
    t = ({1'b0, in_tdata[128 +: CW]} > One) ? One : {1'b0, in_tdata[128 +: CW]};
  end

  logic signed [CW-1:0] f1_r [NumLanes];
  logic signed [CW-1:0] g1_r [NumLanes];
  logic signed [2*CW-1:0] dp1_r [NumLanes];
  logic [CW:0] t1_r;
  logic eq1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      eq1_r <= (f[0] == g[0]) && (f[1] == g[1]) && (f[2] == g[2]) && (f[3] == g[3]);
      t1_r  <= t;
      for (int i = 0; i < NumLanes; i++) begin
        f1_r[i] <= f[i]; g1_r[i] <= g[i]; dp1_r[i] <= f[i] * g[i];
      end
    end
  end

  // stage 2: dot sign, blend products per lane
  logic signed [2*CW+2:0] dot;
  always_comb dot = (2*CW+3)'(dp1_r[0]) + (2*CW+3)'(dp1_r[1])
                  + (2*CW+3)'(dp1_r[2]) + (2*CW+3)'(dp1_r[3]);
  logic signed [PW-1:0] pa2_r [NumLanes];
  logic signed [PW-1:0] pb2_r [NumLanes];
  logic signed [CW-1:0] f2_r [NumLanes];
  logic eq2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      eq2_r <= eq1_r;
      for (int i = 0; i < NumLanes; i++) begin
        f2_r[i]  <= f1_r[i];
        pa2_r[i] <= PW'($signed({f1_r[i][CW-1], f1_r[i]}) * $signed({1'b0, One - t1_r}));
        pb2_r[i] <= dot[2*CW+2]
          ? PW'(-($signed({g1_r[i][CW-1], g1_r[i]}) * $signed({1'b0, t1_r})))
          : PW'($signed({g1_r[i][CW-1], g1_r[i]}) * $signed({1'b0, t1_r}));
      end
    end
  end

  // stage 3: sum, sign and magnitude per lane
  logic [PW-1:0] mag3_r [NumLanes];
  logic neg3_r [NumLanes];
  logic signed [CW-1:0] f3_r [NumLanes];
  logic eq3_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      eq3_r <= eq2_r;
      for (int i = 0; i < NumLanes; i++) begin
        logic signed [PW-1:0] p;
        p = PW'(pa2_r[i] + pb2_r[i]);
        f3_r[i]  <= f2_r[i];
        neg3_r[i] <= p[PW-1];
        mag3_r[i] <= p[PW-1] ? PW'(-p) : p;
      end
    end
  end

  // stage 4: merge across lanes: OR of magnitudes, its leading-bit position, zero flag
  logic [PW-1:0] mx;
  always_comb mx = mag3_r[0] | mag3_r[1] | mag3_r[2] | mag3_r[3];
  logic [$clog2(PW+1)-1:0] msb;
  always_comb begin
    msb = '0;
    for (int b = 0; b < PW; b++) if (mx[b]) msb = ($clog2(PW+1))'(b);
  end
  logic [PW-1:0] mag4_r [NumLanes];
  logic neg4_r [NumLanes];
  logic signed [CW-1:0] f4_r [NumLanes];
  logic [$clog2(PW+1)-1:0] msb4_r;
  logic eq4_r, z4_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      eq4_r <= eq3_r; z4_r <= (mx == '0); msb4_r <= msb;
      for (int i = 0; i < NumLanes; i++) begin
        mag4_r[i] <= mag3_r[i]; neg4_r[i] <= neg3_r[i]; f4_r[i] <= f3_r[i];
      end
    end
  end

  // stage 5: normalise so the largest lane lies in [2^29, 2^30)
  localparam int SW = $clog2(PW+1);
  logic [MagBits-1:0] m5_r [NumLanes];
  logic neg5_r [NumLanes];
  logic signed [CW-1:0] f5_r [NumLanes];
  qnl_ctl_t ctl5_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      ctl5_r <= '{equal: eq4_r, zero: z4_r};
      for (int i = 0; i < NumLanes; i++) begin
        neg5_r[i] <= neg4_r[i]; f5_r[i] <= f4_r[i];
        if (msb4_r >= SW'(MagBits - 1))
          m5_r[i] <= MagBits'(mag4_r[i] >> (msb4_r - SW'(MagBits - 1)));
        else
          m5_r[i] <= MagBits'({{MagBits{1'b0}}, mag4_r[i]} << (SW'(MagBits - 1) - msb4_r));
      end
    end
  end

  // stage 6: squares per lane
  logic [2*MagBits-1:0] sq6_r [NumLanes];
  logic [MagBits-1:0] m6_r [NumLanes];
  logic neg6_r [NumLanes];
  logic signed [CW-1:0] f6_r [NumLanes];
  qnl_ctl_t ctl6_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      ctl6_r <= ctl5_r;
      for (int i = 0; i < NumLanes; i++) begin
        sq6_r[i] <= m5_r[i] * m5_r[i];
        m6_r[i] <= m5_r[i]; neg6_r[i] <= neg5_r[i]; f6_r[i] <= f5_r[i];
      end
    end
  end

  logic [SumBits-1:0] ssum;
  always_comb ssum = SumBits'(sq6_r[0]) + SumBits'(sq6_r[1])
                   + SumBits'(sq6_r[2]) + SumBits'(sq6_r[3]);

  localparam int SIDE = NumLanes * (MagBits + 1 + CW) + $bits(qnl_ctl_t);
  logic [SIDE-1:0] side_in, side_out;
  always_comb begin
    side_in = '0;
    for (int i = 0; i < NumLanes; i++)
      side_in[i*(MagBits+1+CW) +: MagBits+1+CW] = {m6_r[i], neg6_r[i], f6_r[i]};
    side_in[SIDE-1 -: $bits(qnl_ctl_t)] = ctl6_r;
  end

  logic [RootBits-1:0] root;
  qnl_sqrt #(.DW(SumBits), .RW(RootBits), .SW(SIDE)) u_sqrt (
    .clk(clk), .en(adv), .s_in(ssum), .side_in(side_in),
    .root(root), .side_out(side_out)
  );

  qnl_ctl_t ctl_s;
  assign ctl_s = side_out[SIDE-1 -: $bits(qnl_ctl_t)];

  // carry control and from alongside the dividers
  localparam int DL = CW + 1;
  logic [$bits(qnl_ctl_t)+NumLanes*CW-1:0] dly_r [DL];
  logic [$bits(qnl_ctl_t)+NumLanes*CW-1:0] dly_in;
  always_comb begin
    dly_in = '0;
    for (int i = 0; i < NumLanes; i++)
      dly_in[i*CW +: CW] = side_out[i*(MagBits+1+CW) +: CW];
    dly_in[$bits(dly_in)-1 -: $bits(qnl_ctl_t)] = ctl_s;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dly_r[0] <= dly_in;
      for (int k = 1; k < DL; k++) dly_r[k] <= dly_r[k-1];
    end
  end

  logic [CW-1:0] q [NumLanes];
  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    logic [MagBits-1:0] m;
    logic nl;
    assign m  = side_out[i*(MagBits+1+CW) + CW + 1 +: MagBits];
    assign nl = side_out[i*(MagBits+1+CW) + CW];
    qnl_div #(.CW(CW), .NW(NW), .DW(RootBits)) u_div (
      .clk(clk), .en(adv),
      .num(NW'({m, {(CW-1){1'b0}}}) + NW'(root >> 1)),
      .den(root), .neg(nl), .q_out(q[i])
    );
  end

  qnl_ctl_t ctl_o;
  assign ctl_o = dly_r[DL-1][$bits(dly_in)-1 -: $bits(qnl_ctl_t)];

  logic [71:0] out_nxt;
  always_comb begin
    out_nxt = '0;
    for (int i = 0; i < NumLanes; i++) begin
      if (ctl_o.equal) out_nxt[16*i +: CW] = dly_r[DL-1][i*CW +: CW];
      else if (!ctl_o.zero) out_nxt[16*i +: CW] = q[i];
    end
    out_nxt[64] = !ctl_o.equal && ctl_o.zero;
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) out_tdata <= out_nxt;
  end

`include "assert_macros.svh"
  `ASSERT_NEXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "held result changed")
  `ASSERT_IMPL(a_ready, in_tready == (!out_tvalid || out_tready), "ready mismatch")
  `ASSERT_IMPL(a_degen_zero, !(out_tvalid && out_tdata[64]) || out_tdata[63:0] == 64'd0, "degenerate not zero")
endmodule
`default_nettype wire

FILE: tb/sv/tb_quaternion_nlerp_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_nlerp_unit
// Drives quaternion pairs and weights through the nlerp pipeline, predicts the
// normalised blends or uses fixed ones, and checks every output beat in order.
// ----------------------------------------------------------------------------
module tb_quaternion_nlerp_unit;
  import qnl_pkg::*;

  localparam int CB = CompBitsDef;
  localparam int LAT = 5 + RootBits + CB + 1 + 2;
  localparam int NRAND = 1600;
  localparam int NDIR = 16;

  typedef struct packed {
    logic [15:0] wt;
    logic [15:0] tw, tz, ty, tx;
    logic [15:0] fw, fz, fy, fx;
  } nl_in_t;

  typedef struct packed {
    logic [6:0]  pad;
    logic        degen;
    logic [15:0] w, z, y, x;
  } nl_out_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [143:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;

  int idle_pct_in, idle_pct_out;
  nl_out_t blend_q[$];
  int errors, mismatches, n_seen, n_degen, n_equal;

  quaternion_nlerp_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint root64(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic nl_out_t predict_blend(nl_in_t it);
    longint f[4], g[4], p[4], dot, t, tm, q;
    longint unsigned mg[4], mx, s, n;
    bit ng[4], eq;
    nl_out_t r;
    f[0] = $signed(it.fx); f[1] = $signed(it.fy);
    f[2] = $signed(it.fz); f[3] = $signed(it.fw);
    g[0] = $signed(it.tx); g[1] = $signed(it.ty);
    g[2] = $signed(it.tz); g[3] = $signed(it.tw);
    r = '0;
    eq = 1;
    dot = 0;
    for (int i = 0; i < 4; i++) begin
      if (f[i] != g[i]) eq = 0;
      dot += f[i] * g[i];
    end
    t = it.wt;
    if (t > 32768) t = 32768;
    tm = 32768 - t;
    if (eq) begin
      r.x = it.fx; r.y = it.fy; r.z = it.fz; r.w = it.fw;
      return r;
    end
    if (dot < 0) for (int i = 0; i < 4; i++) g[i] = -g[i];
    mx = 0;
    for (int i = 0; i < 4; i++) begin
      p[i] = f[i] * tm + g[i] * t;
      ng[i] = p[i] < 0;
      mg[i] = ng[i] ? -p[i] : p[i];
      if (mg[i] > mx) mx = mg[i];
    end
    if (mx == 0) begin
      r.degen = 1'b1;
      return r;
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 4; i++) mg[i] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 4; i++) mg[i] <<= 1;
    end
    s = 0;
    for (int i = 0; i < 4; i++) s += mg[i] * mg[i];
    n = root64(s);
    for (int i = 0; i < 4; i++) begin
      q = (mg[i] * 32768 + n / 2) / n;
      if (ng[i]) begin
        if (q > 32768) q = 32768;
        q = -q;
      end else if (q > 32767) begin
        q = 32767;
      end
      case (i)
        0: r.x = q[15:0];
        1: r.y = q[15:0];
        2: r.z = q[15:0];
        default: r.w = q[15:0];
      endcase
    end
    return r;
  endfunction

  // hold the beat until accepted; expected result queued when the beat is driven
  task automatic send_item(nl_in_t it, bit has_fixed, nl_out_t fixed);
    while ($urandom_range(99) < idle_pct_in) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= it;
    blend_q.push_back(has_fixed ? fixed : predict_blend(it));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rnd_comp();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($urandom_range(255) - 128);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rnd_weight();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'(16'hFFFF - $urandom_range(3));
      3: return 16'($urandom);
      default: return 16'($urandom_range(32768));
    endcase
  endfunction

  always @(negedge clk) begin
    if (rst_n) out_tready <= ($urandom_range(99) >= idle_pct_out);
  end

  always @(posedge clk) begin
    nl_out_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      n_seen++;
      if (blend_q.size() == 0) begin
        errors++;
        $display("unexpected output beat %h", got);
      end else begin
        exp_r = blend_q.pop_front();
        if (exp_r.degen) n_degen++;
        if (got.x !== exp_r.x || got.y !== exp_r.y || got.z !== exp_r.z ||
            got.w !== exp_r.w || got.degen !== exp_r.degen) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h %h %h %h d%b got %h %h %h %h d%b",
                     exp_r.x, exp_r.y, exp_r.z, exp_r.w, exp_r.degen,
                     got.x, got.y, got.z, got.w, got.degen);
        end
      end
    end
  end

  initial begin
    #100ms;
    $display("tb_quaternion_nlerp_unit failed");
    $finish;
  end

  initial begin
    nl_in_t dir_in[NDIR];
    bit dir_fix[NDIR];
    nl_out_t dir_exp[NDIR];
    nl_in_t it;
    nl_out_t none;
    int k;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    idle_pct_in = 0;
    idle_pct_out = 0;
    errors = 0;
    mismatches = 0;
    n_seen = 0;
    n_degen = 0;
    n_equal = 0;
    none = '0;
    for (int i = 0; i < NDIR; i++) begin
      dir_fix[i] = 0;
      dir_exp[i] = '0;
    end
    // equal inputs, all zero: passed through, no flag
    dir_in[0] = '0; dir_fix[0] = 1;
    // equal extremes: passed through
    dir_in[1] = {16'd100, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
    dir_fix[1] = 1; dir_exp[1] = {8'h0, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
    // from zero, to nonzero, weight zero: blend is zero
    dir_in[2] = {16'd0, 16'd0, 16'd0, 16'd0, 16'd5, 16'd0, 16'd0, 16'd0, 16'd0};
    dir_fix[2] = 1; dir_exp[2] = {7'h0, 1'b1, 64'h0};
    // to zero, weight one: blend is zero
    dir_in[3] = {16'd32768, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h8000};
    dir_fix[3] = 1; dir_exp[3] = {7'h0, 1'b1, 64'h0};
    // weight beyond one saturates
    dir_in[4] = {16'hFFFF, 16'd0, 16'd0, 16'd0, 16'h4000, 16'd0, 16'd0, 16'h4000, 16'd0};
    // dot exactly zero: no flip
    dir_in[5] = {16'd16384, 16'd0, 16'd0, 16'd0, 16'h7FFF, 16'd0, 16'd0, 16'h7FFF, 16'd0};
    // dot negative: flip
    dir_in[6] = {16'd16384, 16'd0, 16'd0, 16'd0, 16'h8000, 16'd0, 16'd0, 16'd0, 16'h4000};
    // output saturation on a single axis
    dir_in[7] = {16'd0, 16'd0, 16'd0, 16'd0, 16'h7FFF, 16'd0, 16'd0, 16'd0, 16'h0001};
    dir_in[8] = {16'd0, 16'd0, 16'd0, 16'd0, 16'h8000, 16'd0, 16'd0, 16'd0, 16'hFFFF};
    dir_in[9] = {16'd32768, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
    dir_in[10] = {16'd1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                  16'h0001, 16'h0000, 16'h0000, 16'h0000};
    dir_in[11] = {16'd32767, 16'h0001, 16'h0002, 16'h0003, 16'h0004,
                  16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
    dir_in[12] = {16'h8000, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                  16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA};
    dir_in[13] = {16'h7FFF, 16'h5A82, 16'h0, 16'h0, 16'h5A82, 16'h0, 16'h5A82, 16'h0, 16'h5A82};
    dir_in[14] = {16'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h1, 16'h1, 16'h1, 16'h1};
    dir_in[15] = {16'h4000, 16'h0, 16'h0, 16'h0, 16'h1, 16'h0, 16'h0, 16'h0, 16'hFFFF};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < NDIR; i++) send_item(dir_in[i], dir_fix[i], dir_exp[i]);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin idle_pct_in = 0;  idle_pct_out = 0;  end
        1: begin idle_pct_in = 72; idle_pct_out = 0;  end
        2: begin idle_pct_in = 0;  idle_pct_out = 72; end
        3: begin idle_pct_in = 12; idle_pct_out = 12; end
        default: begin idle_pct_in = 0; idle_pct_out = 0; end
      endcase
      for (k = 0; k < NRAND / 5; k++) begin
        it.fx = rnd_comp(); it.fy = rnd_comp(); it.fz = rnd_comp(); it.fw = rnd_comp();
        case ($urandom_range(9))
          0: begin
            it.tx = it.fx; it.ty = it.fy; it.tz = it.fz; it.tw = it.fw;
            n_equal++;
          end
          1: begin
            // to is -from: flipped blend equals from
            it.tx = -it.fx; it.ty = -it.fy; it.tz = -it.fz; it.tw = -it.fw;
          end
          2: begin
            it.tx = '0; it.ty = '0; it.tz = '0; it.tw = '0;
          end
          default: begin
            it.tx = rnd_comp(); it.ty = rnd_comp(); it.tz = rnd_comp(); it.tw = rnd_comp();
          end
        endcase
        it.wt = rnd_weight();
        send_item(it, 0, none);
      end
    end
    in_tvalid <= 1'b0;

    k = 0;
    while (blend_q.size() != 0 && k < 200000) begin
      @(posedge clk);
      k++;
    end
    repeat (LAT) @(posedge clk);
    if (blend_q.size() != 0) begin
      errors++;
      $display("%0d expected beats never arrived", blend_q.size());
    end
    $display("checked %0d output beats (%0d degenerate, %0d equal pairs)",
             n_seen, n_degen, n_equal);
    $display("idle phases on both sides, %0d failures", errors);
    if (errors == 0) begin
      $display("tb_quaternion_nlerp_unit passed");
    end else begin
      $display("tb_quaternion_nlerp_unit failed");
    end
    $finish;
  end
endmodule
